>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/nls_pkg.sv
package nls_pkg;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RADIX     = 4'd1,
		PH_LEAD_DOT  = 4'd2,
		PH_INT       = 4'd3,
		PH_DOT_PEND  = 4'd4,
		PH_FRAC      = 4'd5,
		PH_LFRAC     = 4'd6,
		PH_EXP_SIGN  = 4'd7,
		PH_EXP_FIRST = 4'd8,
		PH_EXP_DIG   = 4'd9
	} phase_t;

	localparam logic [1:0] KIND_HEX = 2'd0;
	localparam logic [1:0] KIND_BIN = 2'd1;
	localparam logic [1:0] KIND_OCT = 2'd2;
	localparam logic [1:0] KIND_DEC = 2'd3;

	localparam logic [1:0] TK_INT   = 2'd0;
	localparam logic [1:0] TK_FLOAT = 2'd1;
	localparam logic [1:0] TK_ERR   = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_DIGIT  = 3'd1;
	localparam logic [2:0] ERR_BAD_AFTER = 3'd2;
	localparam logic [2:0] ERR_LONE_DOT  = 3'd3;
	localparam logic [2:0] ERR_DBL_DOT   = 3'd4;
	localparam logic [2:0] ERR_SECOND_PT = 3'd5;
	localparam logic [2:0] ERR_BAD_EXP   = 3'd6;
	localparam logic [2:0] ERR_EMPTY_EXP = 3'd7;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [62:0] VAL_MAX = {63{1'b1}};

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  radix;
		logic [62:0] acc;
		logic        seen_int;
		logic        seen_frac;
	} scan_state_t;

	typedef struct packed {
		logic        emit;
		logic [1:0]  token_kind;
		logic [2:0]  error_code;
		logic [62:0] value;
	} scan_result_t;

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	// {valid, digit value} for the given radix
	function automatic logic [4:0] radix_digit(logic [1:0] r, logic [7:0] c);
		logic [4:0] d;
		d = 5'd0;
		case (r)
			KIND_HEX: begin
				if (is_dec(c))
					d = {1'b1, c[3:0]};
				else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF)))
					d = {1'b1, c[3:0] + 4'd9};
			end
			KIND_BIN: begin
				if ((c == CH_0) || (c == CH_1))
					d = {1'b1, c[3:0]};
			end
			KIND_OCT: begin
				if ((c >= CH_0) && (c <= CH_7))
					d = {1'b1, c[3:0]};
			end
			default: begin
				if (is_dec(c))
					d = {1'b1, c[3:0]};
			end
		endcase
		return d;
	endfunction

endpackage

>>> rtl/nls_step.sv
module nls_step #(
	parameter int LENGTH_WIDTH = 16
) (
	input  logic                     start_req,
	input  logic [1:0]               literal_kind,
	input  logic [7:0]               ch,
	input  logic                     at_end,
	input  nls_pkg::scan_state_t     cur_state,
	input  logic [LENGTH_WIDTH-1:0]  cur_count,
	output nls_pkg::scan_state_t     nxt_state,
	output logic [LENGTH_WIDTH-1:0]  nxt_count,
	output nls_pkg::scan_result_t    result
);
	import nls_pkg::*;

	function automatic logic [LENGTH_WIDTH-1:0] sat_inc(logic [LENGTH_WIDTH-1:0] n);
		return (&n) ? n : n + 1'b1;
	endfunction

	scan_state_t             s;
	logic [LENGTH_WIDTH-1:0] c;
	logic                    run;
	logic                    dg;
	logic                    ee;
	logic                    dot;
	logic                    sgn;
	logic [4:0]              rd;
	logic [67:0]             wide;
	logic [62:0]             mac;
	logic                    frac_dot_err;

	always_comb begin
		s = cur_state;
		c = cur_count;
		run = 1'b1;
		result = '0;
		result.token_kind = TK_INT;
		result.error_code = ERR_NONE;

		if (start_req) begin
			s.radix = literal_kind;
			s.acc = '0;
			s.seen_int = 1'b0;
			s.seen_frac = 1'b0;
			c = '0;
			if (literal_kind != KIND_DEC) begin
				s.phase = PH_RADIX;
			end else if (!at_end && (ch == CH_DOT)) begin
				c = sat_inc(c);
				s.phase = PH_LEAD_DOT;
				run = 1'b0;
			end else begin
				s.phase = PH_INT;
			end
		end else if (cur_state.phase == PH_IDLE) begin
			run = 1'b0;
		end

		dg  = !at_end && is_dec(ch);
		ee  = !at_end && ((ch == CH_LE) || (ch == CH_UE));
		dot = !at_end && (ch == CH_DOT);
		sgn = !at_end && ((ch == CH_PLUS) || (ch == CH_MINUS));
		rd  = at_end ? 5'd0 : radix_digit(s.radix, ch);

		// acc * base + digit, saturating
		case (s.radix)
			KIND_HEX: wide = {1'b0, s.acc, 4'd0};
			KIND_BIN: wide = {4'd0, s.acc, 1'b0};
			KIND_OCT: wide = {2'd0, s.acc, 3'd0};
			default:  wide = {2'd0, s.acc, 3'd0} + {4'd0, s.acc, 1'b0};
		endcase
		wide = wide + {64'd0, rd[3:0]};
		mac = (|wide[67:63]) ? VAL_MAX : wide[62:0];
		frac_dot_err = 1'b0;

		if (run) begin
			case (s.phase)
				PH_RADIX: begin
					if (rd[4]) begin
						s.acc = mac;
						c = sat_inc(c);
						s.seen_int = 1'b1;
					end else if (!s.seen_int) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_NO_DIGIT;
					end else if (!at_end && (is_dec(ch) || is_alpha(ch) || (ch == CH_DOT))) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_BAD_AFTER;
					end else begin
						result.emit = 1'b1;
						result.token_kind = TK_INT;
					end
				end
				PH_LEAD_DOT: begin
					if (!dg) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_LONE_DOT;
					end else begin
						c = sat_inc(c);
						s.seen_frac = 1'b1;
						s.phase = PH_LFRAC;
					end
				end
				PH_INT: begin
					if (dg) begin
						s.acc = mac;
						c = sat_inc(c);
						s.seen_int = 1'b1;
					end else if (dot) begin
						s.phase = PH_DOT_PEND;
					end else if (ee) begin
						if (!s.seen_int && !s.seen_frac) begin
							result.emit = 1'b1;
							result.token_kind = TK_ERR;
							result.error_code = ERR_BAD_EXP;
						end else begin
							c = sat_inc(c);
							s.phase = PH_EXP_SIGN;
						end
					end else begin
						result.emit = 1'b1;
						result.token_kind = TK_INT;
					end
				end
				PH_DOT_PEND, PH_FRAC, PH_LFRAC: begin
					if ((s.phase == PH_DOT_PEND) && dot) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_DBL_DOT;
					end else begin
						// pending dot is counted, then this character is fraction
						if (s.phase == PH_DOT_PEND) begin
							c = sat_inc(c);
							s.phase = PH_FRAC;
						end
						frac_dot_err = dot && (s.phase == PH_FRAC);
						if (dg) begin
							c = sat_inc(c);
							s.seen_frac = 1'b1;
						end else if (frac_dot_err) begin
							result.emit = 1'b1;
							result.token_kind = TK_ERR;
							result.error_code = ERR_SECOND_PT;
						end else if (ee) begin
							if (!s.seen_int && !s.seen_frac) begin
								result.emit = 1'b1;
								result.token_kind = TK_ERR;
								result.error_code = ERR_BAD_EXP;
							end else begin
								c = sat_inc(c);
								s.phase = PH_EXP_SIGN;
							end
						end else begin
							result.emit = 1'b1;
							result.token_kind = TK_FLOAT;
						end
					end
				end
				PH_EXP_SIGN: begin
					if (sgn) begin
						c = sat_inc(c);
						s.phase = PH_EXP_FIRST;
					end else if (!dg) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_EMPTY_EXP;
					end else begin
						c = sat_inc(c);
						s.phase = PH_EXP_DIG;
					end
				end
				PH_EXP_FIRST: begin
					if (!dg) begin
						result.emit = 1'b1;
						result.token_kind = TK_ERR;
						result.error_code = ERR_EMPTY_EXP;
					end else begin
						c = sat_inc(c);
						s.phase = PH_EXP_DIG;
					end
				end
				PH_EXP_DIG: begin
					if (dg) begin
						c = sat_inc(c);
					end else begin
						result.emit = 1'b1;
						result.token_kind = TK_FLOAT;
					end
				end
				default: begin
					s.phase = PH_IDLE;
				end
			endcase
		end

		if (result.emit) begin
			s.phase = PH_IDLE;
			result.value = (result.token_kind == TK_INT) ? s.acc : '0;
		end

		nxt_state = s;
		nxt_count = c;
	end

endmodule

>>> rtl/numeric_literal_scanner_top.sv
// Numeric literal scanner.
// Input channel (char_valid / char_stall): one source character per word with
// start_req, literal_kind, ch and at_end. start_req marks the first character
// of a literal and selects its kind; a start during a literal drops it.
// Output channel (token_valid / token_stall): one token per literal with
// token_kind, value, error_code and length, given when the terminating
// character (or at_end) arrives; the terminator itself is not counted.
// A taken character sits in the input register and is decoded from it; its
// token is registered into the output register when the character advances.
// Throughput: one character per cycle while char_stall is low; the decode is one
// pass of the phase machine plus a shift-add multiply by the radix.
// While a token waits under token_stall, the input register still takes one
// character; it is held, and char_stall rises, only if it would also end a
// literal. Characters that end nothing keep flowing.
// Reset (arst_n low) empties both registers and returns the scanner to idle;
// characters without start_req are ignored while idle.
module numeric_literal_scanner_top #(
	parameter int LENGTH_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    char_valid,
	output logic                    char_stall,
	input  logic                    start_req,
	input  logic [1:0]              literal_kind,
	input  logic [7:0]              ch,
	input  logic                    at_end,
	output logic                    token_valid,
	input  logic                    token_stall,
	output logic [1:0]              token_kind,
	output logic [62:0]             value,
	output logic [2:0]              error_code,
	output logic [LENGTH_WIDTH-1:0] length
);
	import nls_pkg::*;

	logic                    valid_s1;
	logic                    start_s1;
	logic [1:0]              kind_s1;
	logic [7:0]              ch_s1;
	logic                    end_s1;

	scan_state_t             state_q;
	logic [LENGTH_WIDTH-1:0] count_q;
	scan_state_t             nxt_state;
	logic [LENGTH_WIDTH-1:0] nxt_count;
	scan_result_t            result;

	logic                    token_valid_q;
	logic [1:0]              token_kind_q;
	logic [62:0]             value_q;
	logic [2:0]              error_code_q;
	logic [LENGTH_WIDTH-1:0] length_q;

	logic                    out_busy;
	logic                    advance;
	logic                    load;

	nls_step #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_step (
		.start_req    (start_s1),
		.literal_kind (kind_s1),
		.ch           (ch_s1),
		.at_end       (end_s1),
		.cur_state    (state_q),
		.cur_count    (count_q),
		.nxt_state    (nxt_state),
		.nxt_count    (nxt_count),
		.result       (result)
	);

	assign out_busy   = token_valid_q && token_stall;
	assign advance    = valid_s1 && !(result.emit && out_busy);
	assign char_stall = valid_s1 && !advance;
	assign load       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_s1 <= start_req;
			kind_s1  <= literal_kind;
			ch_s1    <= ch;
			end_s1   <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, radix: KIND_HEX, acc: '0, seen_int: 1'b0,
				seen_frac: 1'b0};
			count_q <= '0;
		end else if (advance) begin
			state_q <= nxt_state;
			count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else if (advance && result.emit) begin
			token_valid_q <= 1'b1;
		end else if (!token_stall) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			token_kind_q <= result.token_kind;
			value_q      <= result.value;
			error_code_q <= result.error_code;
			length_q     <= nxt_count;
		end
	end

	assign token_valid = token_valid_q;
	assign token_kind  = token_kind_q;
	assign value       = value_q;
	assign error_code  = error_code_q;
	assign length      = length_q;

endmodule

>>> rtl/nls_checker.sv
`include "assert_macros.svh"

module nls_checker #(
	parameter int LENGTH_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    token_valid,
	input logic                    token_stall,
	input logic [1:0]              token_kind,
	input logic [62:0]             value,
	input logic [2:0]              error_code,
	input logic [LENGTH_WIDTH-1:0] length
);
	import nls_pkg::*;

	// a held token stays offered
	`ASSERT_NEXT(a_hold, clk, arst_n, token_valid && token_stall, token_valid)

	// only integers carry a value
	`ASSERT_IMPLIES(a_value_zero, clk, arst_n, token_valid && (token_kind != TK_INT), value == 63'd0)

	// error code set exactly for error tokens
	`ASSERT_IMPLIES(a_code_kind, clk, arst_n, token_valid, (token_kind == TK_ERR) == (error_code != ERR_NONE))

	// a radix literal with no digit consumed nothing
	`ASSERT_IMPLIES(a_nodigit_len, clk, arst_n, token_valid && (error_code == ERR_NO_DIGIT), length == '0)

endmodule

bind numeric_literal_scanner_top nls_checker #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_nls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_kind  (token_kind),
	.value       (value),
	.error_code  (error_code),
	.length      (length)
);
